[rtl/baa_pkg.sv]
// Shared constants and types for the boid alignment accumulator.
package baa_pkg;

  localparam int unsigned MAX_NEIGHBORS = 256;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [31:0] RADIUS_RESET = 32'd3276800;
  localparam logic [31:0] SAT_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN      = 32'h8000_0000;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_t;

endpackage

[rtl/baa_front.sv]
// Front end: takes neighbor items, keeps the running sums and hands finished groups on.
module baa_front #(
  parameter int unsigned MAX_NEIGHBORS = baa_pkg::MAX_NEIGHBORS,
  parameter int unsigned CNT_W         = 9,
  parameter int unsigned SUM_W         = 41,
  parameter int unsigned REC_W         = 2 * SUM_W + CNT_W + 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_accept,
  input  logic                in_first,
  input  logic                in_last,
  input  logic [31:0]         in_distance,
  input  logic signed [31:0]  in_nbr_vel_x,
  input  logic signed [31:0]  in_nbr_vel_y,
  input  logic signed [31:0]  in_own_vel_x,
  input  logic signed [31:0]  in_own_vel_y,
  output logic                rec_push,
  output logic [REC_W-1:0]    rec_data
);

  logic [31:0]             radius_r;
  logic signed [SUM_W-1:0] sum_x_r, sum_x_nxt;
  logic signed [SUM_W-1:0] sum_y_r, sum_y_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] base_x, base_y;
  logic [CNT_W-1:0]        base_cnt;
  logic                    hit;

  // A first item starts the group from zero before its own neighbor is applied.
  always_comb begin
    base_x   = in_first ? '0 : sum_x_r;
    base_y   = in_first ? '0 : sum_y_r;
    base_cnt = in_first ? '0 : cnt_r;
    hit      = (in_distance < radius_r) && (base_cnt < CNT_W'(MAX_NEIGHBORS));
    sum_x_nxt = hit ? base_x + SUM_W'(in_nbr_vel_x) : base_x;
    sum_y_nxt = hit ? base_y + SUM_W'(in_nbr_vel_y) : base_y;
    cnt_nxt   = hit ? base_cnt + CNT_W'(1) : base_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= baa_pkg::RADIUS_RESET;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
      if (in_accept) begin
        sum_x_r <= sum_x_nxt;
        sum_y_r <= sum_y_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  assign rec_push = in_accept && in_last;
  assign rec_data = {sum_x_nxt, sum_y_nxt, cnt_nxt, in_own_vel_x, in_own_vel_y};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_NEIGHBORS))
    else $error("neighbor count above its limit");

endmodule

[rtl/baa_queue.sv]
// Small register queue between the front end and the divide back end.
module baa_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = baa_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LVL_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [LVL_W-1:0] level_r;
  logic             do_wr, do_rd;

  assign full    = (level_r == LVL_W'(DEPTH));
  assign empty   = (level_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_rd) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_wr && !do_rd) begin
        level_r <= level_r + LVL_W'(1);
      end else if (do_rd && !do_wr) begin
        level_r <= level_r - LVL_W'(1);
      end
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(DEPTH))
    else $error("queue level above depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("group record pushed into a full queue");

endmodule

[rtl/baa_back.sv]
// Back end: divides each group's sums by its count, subtracts own velocity, saturates.
module baa_back #(
  parameter int unsigned CNT_W = 9,
  parameter int unsigned SUM_W = 41,
  parameter int unsigned REC_W = 2 * SUM_W + CNT_W + 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rec_empty,
  input  logic [REC_W-1:0]    rec_data,
  output logic                rec_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic signed [31:0]  out_impulse_x,
  output logic signed [31:0]  out_impulse_y,
  output logic [CNT_W-1:0]    out_neighbors_seen
);

  localparam int unsigned STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;
  localparam int unsigned DIFF_W = SUM_W + 2;

  baa_pkg::back_state_t state_r, state_nxt;

  logic signed [SUM_W-1:0] rq_sx, rq_sy;
  logic [CNT_W-1:0]        rq_cnt;
  logic signed [31:0]      rq_ox, rq_oy;

  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [SUM_W-1:0]  q_x_r, q_x_nxt, q_y_r, q_y_nxt;
  logic [CNT_W-1:0]  rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  logic              neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic signed [31:0] own_x_r, own_x_nxt, own_y_r, own_y_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic [CNT_W:0]    trial_x, trial_y;
  logic              ge_x, ge_y;
  logic              load_out;
  logic [31:0]       res_x, res_y;

  logic              out_valid_r;
  logic [31:0]       out_x_r, out_y_r;
  logic [CNT_W-1:0]  out_cnt_r;

  assign {rq_sx, rq_sy, rq_cnt, rq_ox, rq_oy} = rec_data;

  // One restoring-division step per cycle for both axes.
  always_comb begin
    trial_x = {rem_x_r, q_x_r[SUM_W-1]};
    trial_y = {rem_y_r, q_y_r[SUM_W-1]};
    ge_x    = trial_x >= {1'b0, div_r};
    ge_y    = trial_y >= {1'b0, div_r};
  end

  function automatic logic [31:0] finish(input logic [SUM_W-1:0] q, input logic neg,
                                         input logic signed [31:0] own);
    logic signed [DIFF_W-1:0] avg;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-32:0]       hi;
    avg  = neg ? -$signed(DIFF_W'(q)) : $signed(DIFF_W'(q));
    diff = avg - DIFF_W'(own);
    hi   = diff[DIFF_W-1:31];
    if ((&hi) || !(|hi)) begin
      finish = diff[31:0];
    end else if (diff[DIFF_W-1]) begin
      finish = baa_pkg::SAT_MIN;
    end else begin
      finish = baa_pkg::SAT_MAX;
    end
  endfunction

  assign res_x    = finish(q_x_r, neg_x_r, own_x_r);
  assign res_y    = finish(q_y_r, neg_y_r, own_y_r);
  assign load_out = (state_r == baa_pkg::BK_FIN) && (!out_valid_r || out_pop);

  always_comb begin
    state_nxt = state_r;
    rec_pop   = 1'b0;
    div_nxt   = div_r;
    q_x_nxt   = q_x_r;
    q_y_nxt   = q_y_r;
    rem_x_nxt = rem_x_r;
    rem_y_nxt = rem_y_r;
    neg_x_nxt = neg_x_r;
    neg_y_nxt = neg_y_r;
    own_x_nxt = own_x_r;
    own_y_nxt = own_y_r;
    step_nxt  = step_r;
    unique case (state_r)
      baa_pkg::BK_IDLE: begin
        if (!rec_empty) begin
          rec_pop   = 1'b1;
          div_nxt   = rq_cnt;
          neg_x_nxt = rq_sx[SUM_W-1];
          neg_y_nxt = rq_sy[SUM_W-1];
          q_x_nxt   = rq_sx[SUM_W-1] ? -rq_sx : rq_sx;
          q_y_nxt   = rq_sy[SUM_W-1] ? -rq_sy : rq_sy;
          rem_x_nxt = '0;
          rem_y_nxt = '0;
          step_nxt  = STEP_W'(SUM_W - 1);
          // With no neighbors counted the result is zero, own velocity included.
          if (rq_cnt == '0) begin
            q_x_nxt   = '0;
            q_y_nxt   = '0;
            neg_x_nxt = 1'b0;
            neg_y_nxt = 1'b0;
            own_x_nxt = '0;
            own_y_nxt = '0;
            state_nxt = baa_pkg::BK_FIN;
          end else begin
            own_x_nxt = rq_ox;
            own_y_nxt = rq_oy;
            state_nxt = baa_pkg::BK_DIV;
          end
        end
      end
      baa_pkg::BK_DIV: begin
        rem_x_nxt = ge_x ? CNT_W'(trial_x - {1'b0, div_r}) : trial_x[CNT_W-1:0];
        rem_y_nxt = ge_y ? CNT_W'(trial_y - {1'b0, div_r}) : trial_y[CNT_W-1:0];
        q_x_nxt   = {q_x_r[SUM_W-2:0], ge_x};
        q_y_nxt   = {q_y_r[SUM_W-2:0], ge_y};
        if (step_r == '0) begin
          state_nxt = baa_pkg::BK_FIN;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      baa_pkg::BK_FIN: begin
        if (load_out) begin
          state_nxt = baa_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = baa_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= baa_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    div_r   <= div_nxt;
    q_x_r   <= q_x_nxt;
    q_y_r   <= q_y_nxt;
    rem_x_r <= rem_x_nxt;
    rem_y_r <= rem_y_nxt;
    neg_x_r <= neg_x_nxt;
    neg_y_r <= neg_y_nxt;
    own_x_r <= own_x_nxt;
    own_y_r <= own_y_nxt;
    step_r  <= step_nxt;
    if (load_out) begin
      out_x_r   <= res_x;
      out_y_r   <= res_y;
      out_cnt_r <= div_r;
    end
  end

  assign out_empty          = !out_valid_r;
  assign out_impulse_x      = out_x_r;
  assign out_impulse_y      = out_y_r;
  assign out_neighbors_seen = out_cnt_r;

  a_zero_group: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_neighbors_seen == '0)) |->
      ((out_impulse_x == '0) && (out_impulse_y == '0)))
    else $error("empty group gave a nonzero impulse");

endmodule

[rtl/boid_alignment_accumulator.sv]
// Top level of the boid alignment accumulator: front end, group queue and divide back end.
//
//   port group  direction  handshake          payload
//   in_*        input      in_push / in_full  first, last, distance, nbr_vel_x/y, own_vel_x/y
//   out_*       output     out_pop / out_empty impulse_x/y, neighbors_seen
//   cfg_*       input      cfg_we             perception_radius
//
// The front end takes one item per cycle while in_full is low and updates the sums in that cycle.
// In the back end a group result goes through a fetch from the queue, one divide step
// per sum bit (skipped for an empty group), then a saturate and load.
// in_full rises only while the queue between the two ends is full of groups.
// Reset is synchronous; sums, count and radius take their reset values on a clock edge with rst_n low.
module boid_alignment_accumulator #(
  parameter int unsigned MAX_NEIGHBORS = baa_pkg::MAX_NEIGHBORS,
  parameter int unsigned QUEUE_DEPTH   = baa_pkg::QUEUE_DEPTH,
  localparam int unsigned CNT_W        = $clog2(MAX_NEIGHBORS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_first,
  input  logic                in_last,
  input  logic [31:0]         in_distance,
  input  logic signed [31:0]  in_nbr_vel_x,
  input  logic signed [31:0]  in_nbr_vel_y,
  input  logic signed [31:0]  in_own_vel_x,
  input  logic signed [31:0]  in_own_vel_y,
  output logic                out_empty,
  input  logic                out_pop,
  output logic signed [31:0]  out_impulse_x,
  output logic signed [31:0]  out_impulse_y,
  output logic [CNT_W-1:0]    out_neighbors_seen
);

  localparam int unsigned SUM_W = 32 + CNT_W;
  localparam int unsigned REC_W = 2 * SUM_W + CNT_W + 64;

  logic             in_accept;
  logic             rec_push, rec_pop, rec_empty;
  logic [REC_W-1:0] rec_wdata, rec_rdata;

  assign in_accept = in_push && !in_full;

  baa_front #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .CNT_W         (CNT_W),
    .SUM_W         (SUM_W),
    .REC_W         (REC_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_accept    (in_accept),
    .in_first     (in_first),
    .in_last      (in_last),
    .in_distance  (in_distance),
    .in_nbr_vel_x (in_nbr_vel_x),
    .in_nbr_vel_y (in_nbr_vel_y),
    .in_own_vel_x (in_own_vel_x),
    .in_own_vel_y (in_own_vel_y),
    .rec_push     (rec_push),
    .rec_data     (rec_wdata)
  );

  baa_queue #(
    .W     (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rec_push),
    .wr_data (rec_wdata),
    .full    (in_full),
    .rd_en   (rec_pop),
    .rd_data (rec_rdata),
    .empty   (rec_empty)
  );

  baa_back #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W),
    .REC_W (REC_W)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .rec_empty          (rec_empty),
    .rec_data           (rec_rdata),
    .rec_pop            (rec_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_impulse_x      (out_impulse_x),
    .out_impulse_y      (out_impulse_y),
    .out_neighbors_seen (out_neighbors_seen)
  );

endmodule

[tb/alignment_checker.sv]
// Checker for the boid alignment accumulator: tracks the group sums and compares each impulse.
module alignment_checker #(
  parameter int unsigned SEEN_W = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_push,
  input  logic                in_full,
  input  logic                in_first,
  input  logic                in_last,
  input  logic [31:0]         in_distance,
  input  logic signed [31:0]  in_nbr_vel_x,
  input  logic signed [31:0]  in_nbr_vel_y,
  input  logic signed [31:0]  in_own_vel_x,
  input  logic signed [31:0]  in_own_vel_y,
  input  logic                out_empty,
  input  logic                out_pop,
  input  logic signed [31:0]  out_impulse_x,
  input  logic signed [31:0]  out_impulse_y,
  input  logic [SEEN_W-1:0]   out_neighbors_seen,
  output int                  mismatches,
  output int                  awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] ix;
    logic signed [31:0] iy;
    logic [SEEN_W-1:0]  seen;
  } impulse_t;

  logic [31:0]        radius_q = baa_pkg::RADIUS_RESET;
  logic signed [40:0] sum_x_q = '0;
  logic signed [40:0] sum_y_q = '0;
  logic [SEEN_W-1:0]  count_q = '0;
  impulse_t           impulses_due[$];

  // Average of the counted neighbors minus the own velocity, clamped to 32 bits.
  function automatic logic signed [31:0] steer(input logic signed [40:0] total,
                                               input logic [SEEN_W-1:0] n,
                                               input logic signed [31:0] own);
    longint avg;
    longint diff;
    avg  = longint'(total) / longint'(n);
    diff = avg - longint'(own);
    if (diff > 64'sh7FFF_FFFF) return baa_pkg::SAT_MAX;
    if (diff < -64'sh8000_0000) return baa_pkg::SAT_MIN;
    return diff[31:0];
  endfunction

  always @(posedge clk) begin
    impulse_t want;
    if (!rst_n) begin
      radius_q = baa_pkg::RADIUS_RESET;
      sum_x_q  = '0;
      sum_y_q  = '0;
      count_q  = '0;
      impulses_due.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (impulses_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected impulse: x=%0d y=%0d n=%0d",
                     out_impulse_x, out_impulse_y, out_neighbors_seen);
          mismatches++;
        end else begin
          want = impulses_due.pop_front();
          if (out_impulse_x !== want.ix || out_impulse_y !== want.iy ||
              out_neighbors_seen !== want.seen) begin
            if (mismatches < 10)
              $display("impulse mismatch: expected x=%0d y=%0d n=%0d, got x=%0d y=%0d n=%0d",
                       want.ix, want.iy, want.seen,
                       out_impulse_x, out_impulse_y, out_neighbors_seen);
            mismatches++;
          end
        end
      end
      if (in_push && !in_full) begin
        if (in_first) begin
          sum_x_q = '0;
          sum_y_q = '0;
          count_q = '0;
        end
        // Once the count is full, close neighbors no longer touch the sums.
        if (in_distance < radius_q && count_q < baa_pkg::MAX_NEIGHBORS) begin
          sum_x_q = sum_x_q + 41'(in_nbr_vel_x);
          sum_y_q = sum_y_q + 41'(in_nbr_vel_y);
          count_q = count_q + 1'b1;
        end
        if (in_last) begin
          if (count_q == 0) begin
            want = '0;
          end else begin
            want.ix   = steer(sum_x_q, count_q, in_own_vel_x);
            want.iy   = steer(sum_y_q, count_q, in_own_vel_y);
            want.seen = count_q;
          end
          impulses_due.push_back(want);
        end
      end
      if (cfg_we) radius_q = cfg_wdata;
    end
    awaiting <= impulses_due.size();
  end

endmodule

[tb/testbench.sv]
// Top of the boid alignment accumulator testbench: clock, reset, item stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SEEN_W      = $clog2(baa_pkg::MAX_NEIGHBORS + 1);
  localparam int          DRAIN_CYCLES = 60;
  localparam int          HOLD_CYCLES  = 600;
  localparam int          CYCLE_LIMIT  = 400000;

  typedef struct {
    logic               first;
    logic               last;
    logic [31:0]        distance;
    logic signed [31:0] nbr_x;
    logic signed [31:0] nbr_y;
    logic signed [31:0] own_x;
    logic signed [31:0] own_y;
  } sighting_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [31:0]        cfg_wdata = '0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic               in_first = 1'b0;
  logic               in_last = 1'b0;
  logic [31:0]        in_distance = '0;
  logic signed [31:0] in_nbr_vel_x = '0;
  logic signed [31:0] in_nbr_vel_y = '0;
  logic signed [31:0] in_own_vel_x = '0;
  logic signed [31:0] in_own_vel_y = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [31:0] out_impulse_x;
  logic signed [31:0] out_impulse_y;
  logic [SEEN_W-1:0]  out_neighbors_seen;

  int mismatches;
  int awaiting;
  int cycles = 0;
  int sent = 0;
  bit hold_req = 1'b0;

  boid_alignment_accumulator uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_first           (in_first),
    .in_last            (in_last),
    .in_distance        (in_distance),
    .in_nbr_vel_x       (in_nbr_vel_x),
    .in_nbr_vel_y       (in_nbr_vel_y),
    .in_own_vel_x       (in_own_vel_x),
    .in_own_vel_y       (in_own_vel_y),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_impulse_x      (out_impulse_x),
    .out_impulse_y      (out_impulse_y),
    .out_neighbors_seen (out_neighbors_seen)
  );

  alignment_checker #(.SEEN_W(SEEN_W)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_first           (in_first),
    .in_last            (in_last),
    .in_distance        (in_distance),
    .in_nbr_vel_x       (in_nbr_vel_x),
    .in_nbr_vel_y       (in_nbr_vel_y),
    .in_own_vel_x       (in_own_vel_x),
    .in_own_vel_y       (in_own_vel_y),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_impulse_x      (out_impulse_x),
    .out_impulse_y      (out_impulse_y),
    .out_neighbors_seen (out_neighbors_seen),
    .mismatches         (mismatches),
    .awaiting           (awaiting)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("boid_alignment_accumulator test failed");
      $finish;
    end
  end

  // Mostly back to back, sometimes a few cycles, now and then a long pause.
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [31:0] pick_distance(input logic [31:0] r, input bit dense);
    case ($urandom_range(dense ? 31 : 7, 0))
      0: return r;
      1: return r + 1;
      2: return r - 1;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0;
      5: return $urandom();
      default: return (r == 0) ? 32'h0 : $urandom_range(r - 1, 0);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_velocity();
    case ($urandom_range(7, 0))
      0: return baa_pkg::SAT_MAX;
      1: return baa_pkg::SAT_MIN;
      6, 7: return $urandom();
      default: return 32'($urandom_range(13107200, 0)) - 32'd6553600;
    endcase
  endfunction

  function automatic sighting_t sighting(input bit f, input bit l, input logic [31:0] d,
                                         input logic signed [31:0] vx, input logic signed [31:0] vy,
                                         input logic signed [31:0] ox, input logic signed [31:0] oy);
    sighting_t s;
    s.first = f;  s.last  = l;  s.distance = d;
    s.nbr_x = vx; s.nbr_y = vy; s.own_x = ox; s.own_y = oy;
    return s;
  endfunction

  // Called right after a rising edge; returns right after the edge that took the item.
  task automatic push_sighting(input sighting_t s, input int gap);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_first     <= s.first;
    in_last      <= s.last;
    in_distance  <= s.distance;
    in_nbr_vel_x <= s.nbr_x;
    in_nbr_vel_y <= s.nbr_y;
    in_own_vel_x <= s.own_x;
    in_own_vel_y <= s.own_y;
    do @(posedge clk); while (in_full);
    sent++;
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_radius(input logic [31:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic play_group(input int len, input bit well_formed, input bit dense,
                            input bit steady, input logic [31:0] radius);
    sighting_t s;
    for (int k = 0; k < len; k++) begin
      s.first    = well_formed ? (k == 0) : ($urandom_range(3, 0) == 0);
      s.last     = well_formed ? (k == len - 1) : ($urandom_range(3, 0) == 0);
      s.distance = pick_distance(radius, dense);
      s.nbr_x    = pick_velocity();
      s.nbr_y    = pick_velocity();
      s.own_x    = pick_velocity();
      s.own_y    = pick_velocity();
      push_sighting(s, steady ? 0 : idle_len());
    end
  endtask

  // Result side: bursts of pops with random pauses, and one long hold-off.
  initial begin : result_sink
    int run;
    int gap;
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      run = $urandom_range(60, 1);
      out_pop <= 1'b1;
      repeat (run) @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = idle_len();
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] radius;
    int quota;
    int len;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    radius = baa_pkg::RADIUS_RESET;
    // Extremes saturate both ways.
    push_sighting(sighting(1, 1, 0, baa_pkg::SAT_MAX, baa_pkg::SAT_MIN,
                           baa_pkg::SAT_MIN, baa_pkg::SAT_MAX), idle_len());
    // A distance equal to the radius is not counted, so the own velocity is not used.
    push_sighting(sighting(1, 1, radius, 5, 5, 9, 9), idle_len());
    push_sighting(sighting(1, 1, 32'hFFFF_FFFF, 5, 5, 9, 9), idle_len());
    // Negative sums truncate toward zero.
    push_sighting(sighting(1, 0, radius - 1, -3, 7, 0, 0), idle_len());
    push_sighting(sighting(0, 1, 0, -4, 0, 0, 0), idle_len());
    // No first: the item adds onto the group that was already reported.
    push_sighting(sighting(0, 1, 1, 1, -1, 100, -100), idle_len());
    // A group where nobody is close enough reports zero.
    push_sighting(sighting(1, 0, radius + 1, 3, 3, 0, 0), idle_len());
    push_sighting(sighting(0, 0, radius, 3, 3, 0, 0), idle_len());
    push_sighting(sighting(0, 1, 32'hFFFF_FFFF, 3, 3, 77, 77), idle_len());
    push_sighting(sighting(1, 0, 0, baa_pkg::SAT_MAX, baa_pkg::SAT_MAX, 0, 0), idle_len());
    push_sighting(sighting(0, 0, 0, baa_pkg::SAT_MAX, baa_pkg::SAT_MAX, 0, 0), idle_len());
    push_sighting(sighting(0, 1, 0, baa_pkg::SAT_MAX, baa_pkg::SAT_MAX, -1, -1), idle_len());
    push_sighting(sighting(1, 0, 0, baa_pkg::SAT_MIN, baa_pkg::SAT_MIN, 0, 0), idle_len());
    push_sighting(sighting(0, 1, 0, baa_pkg::SAT_MIN, baa_pkg::SAT_MIN, 1, 1), idle_len());
    push_sighting(sighting(1, 1, 0, -1, -1, -1, -1), idle_len());
    // Items with no last keep accumulating until one arrives.
    push_sighting(sighting(1, 0, 0, 10, 20, 0, 0), idle_len());
    push_sighting(sighting(0, 0, 0, 30, 40, 0, 0), idle_len());
    push_sighting(sighting(0, 1, 0, 0, 0, 0, 0), idle_len());
    push_sighting(sighting(1, 1, radius - 1, 32'h5555_5555, 32'hAAAA_AAAA,
                           32'hAAAA_AAAA, 32'h5555_5555), idle_len());

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: radius = 32'h0;
        1: radius = 32'hFFFF_FFFF;
        2: radius = $urandom();
        3: radius = $urandom_range(32'h0040_0000, 1);
        default: radius = 32'h1;
      endcase
      set_radius(radius);
      if (p == 1) begin
        // The receiver stops for a while so the group queue backs up.
        hold_req = 1'b1;
        // One long group drives the neighbor count into its ceiling.
        play_group($urandom_range(320, 300), 1'b1, 1'b1, 1'b1, radius);
      end
      quota = sent + 70;
      while (sent < quota) begin
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
        play_group(len, $urandom_range(4, 0) != 0, 1'b0, p == 1 || p == 3, radius);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("boid_alignment_accumulator test passed");
    end else begin
      $display("boid_alignment_accumulator test failed");
    end
    $finish;
  end

endmodule
